### hw/rtl/cbbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbbt_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned HOST_ID_BITS  = 16;
  localparam int unsigned IdxW          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ApbAddrW      = 5;
  localparam int unsigned ApbDataW      = 32;

  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [HOST_ID_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_SUCCESS = 2'd1,
    OP_FAILURE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_ENABLE           = 3'd0,
    REG_THRESHOLD        = 3'd1,
    REG_COOLDOWN_INITIAL = 3'd2,
    REG_COOLDOWN_MAX     = 3'd3,
    REG_IDLE_LIMIT       = 3'd4,
    REG_REAP_INTERVAL    = 3'd5
  } reg_e;

  typedef struct packed {
    logic        enable;
    logic [7:0]  threshold;
    logic [7:0]  cooldown_initial;
    logic [7:0]  cooldown_max;
    logic [15:0] idle_limit;
    logic [15:0] reap_interval;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enable:           1'b0,
    threshold:        8'd0,
    cooldown_initial: 8'd2,
    cooldown_max:     8'd60,
    idle_limit:       16'd3600,
    reap_interval:    16'd60
  };

  typedef struct packed {
    key_t        host;
    logic [7:0]  fail_count;
    logic [7:0]  skip_count;
    logic [7:0]  next_backoff;
    logic [31:0] last_active;
  } entry_t;

  typedef struct packed {
    logic       skip;
    logic       tripped;
    logic [7:0] trip_cycles;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/cbbt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbbt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] host_id;
  logic [31:0] now_seconds;

  modport source (output valid, operation, host_id, now_seconds, input ready);
  modport sink   (input valid, operation, host_id, now_seconds, output ready);
endinterface

interface cbbt_rsp_if;
  logic       valid;
  logic       ready;
  logic       skip;
  logic       tripped;
  logic [7:0] trip_cycles;

  modport source (output valid, skip, tripped, trip_cycles, input ready);
  modport sink   (input valid, skip, tripped, trip_cycles, output ready);
endinterface

`default_nettype wire

### hw/rtl/cbbt_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cbbt_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cbbt_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [cbbt_pkg::ApbDataW-1:0]    pwdata,
  output      logic [cbbt_pkg::ApbDataW-1:0]    prdata,
  output      logic                             pready,
  output      cbbt_pkg::cfg_t                   cfg_o
);

  cbbt_pkg::cfg_t cfg_q, cfg_d;
  cbbt_pkg::reg_e sel;

  assign sel    = cbbt_pkg::reg_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (sel)
        cbbt_pkg::REG_ENABLE:           cfg_d.enable           = pwdata[0];
        cbbt_pkg::REG_THRESHOLD:        cfg_d.threshold        = pwdata[7:0];
        cbbt_pkg::REG_COOLDOWN_INITIAL: cfg_d.cooldown_initial = pwdata[7:0];
        cbbt_pkg::REG_COOLDOWN_MAX:     cfg_d.cooldown_max     = pwdata[7:0];
        cbbt_pkg::REG_IDLE_LIMIT:       cfg_d.idle_limit       = pwdata[15:0];
        cbbt_pkg::REG_REAP_INTERVAL:    cfg_d.reap_interval    = pwdata[15:0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      cbbt_pkg::REG_ENABLE:           prdata = {31'd0, cfg_q.enable};
      cbbt_pkg::REG_THRESHOLD:        prdata = {24'd0, cfg_q.threshold};
      cbbt_pkg::REG_COOLDOWN_INITIAL: prdata = {24'd0, cfg_q.cooldown_initial};
      cbbt_pkg::REG_COOLDOWN_MAX:     prdata = {24'd0, cfg_q.cooldown_max};
      cbbt_pkg::REG_IDLE_LIMIT:       prdata = {16'd0, cfg_q.idle_limit};
      cbbt_pkg::REG_REAP_INTERVAL:    prdata = {16'd0, cfg_q.reap_interval};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cbbt_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/circuit_breaker_backoff_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake        Word
// req_i     in   valid / ready    operation, host_id, now_seconds
// rsp_o     out  valid / ready    skip, tripped, trip_cycles
// APB       in   psel / penable   six registers at byte address 4*i
//
// Clear, or breaker off: straight to the answer. Otherwise the search reads each entry and then
// checks it, through the single read port, plus an update step when an entry is written.
// A written success or non-tripping failure record adds a test of the reap interval;
// a sweep that runs reads and checks all TABLE_ENTRIES entries, and the answer goes out after it.
// Reset clears the valid bits, last sweep time and registers; table contents need none.
// req_i is ready only between words; a second result waiting behind rsp_o holds the block.

module circuit_breaker_backoff_table (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  cbbt_req_if.sink                              req_i,
  cbbt_rsp_if.source                            rsp_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cbbt_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [cbbt_pkg::ApbDataW-1:0]    pwdata,
  output      logic [cbbt_pkg::ApbDataW-1:0]    prdata,
  output      logic                             pready
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_FIND_RD  = 8'b0000_0010,
    S_FIND_CHK = 8'b0000_0100,
    S_UPDATE   = 8'b0000_1000,
    S_SW_TEST  = 8'b0001_0000,
    S_SW_RD    = 8'b0010_0000,
    S_SW_CHK   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  cbbt_pkg::cfg_t cfg;

  cbbt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e                              state_q, state_d;
  cbbt_pkg::idx_t                      idx_q, idx_d;
  cbbt_pkg::idx_t                      slot_q, slot_d;
  cbbt_pkg::idx_t                      free_q, free_d;
  logic                                found_q, found_d;
  logic                                free_found_q, free_found_d;
  logic [cbbt_pkg::TABLE_ENTRIES-1:0]  valid_q, valid_d;
  logic [31:0]                         last_sweep_q, last_sweep_d;
  cbbt_pkg::op_e                       op_q, op_d;
  cbbt_pkg::key_t                      key_q, key_d;
  logic [31:0]                         now_q, now_d;
  cbbt_pkg::result_t                   res_q, res_d;
  cbbt_pkg::result_t                   out_q, out_d;
  logic                                out_valid_q, out_valid_d;

  cbbt_pkg::entry_t mem [cbbt_pkg::TABLE_ENTRIES];
  cbbt_pkg::entry_t rdata_q;
  logic             mem_we;

  // Entry update
  cbbt_pkg::entry_t  base, upd;
  cbbt_pkg::result_t upd_res;
  logic              upd_sweep;
  logic [7:0]        half;
  logic [8:0]        doubled;
  logic [7:0]        fail_inc;

  always_comb begin
    if (found_q) begin
      base = rdata_q;
    end else begin
      base = '{host: key_q, fail_count: 8'd0, skip_count: 8'd0,
               next_backoff: cfg.cooldown_initial, last_active: now_q};
    end
    upd       = base;
    upd_res   = '0;
    upd_sweep = 1'b0;
    half      = {1'b0, base.next_backoff[7:1]};
    doubled   = {base.next_backoff, 1'b0};
    fail_inc  = (base.fail_count == 8'hFF) ? 8'hFF : base.fail_count + 8'd1;
    unique case (op_q)
      cbbt_pkg::OP_QUERY: begin
        if (base.skip_count != 8'd0) begin
          upd.skip_count = base.skip_count - 8'd1;
          upd_res.skip   = 1'b1;
        end
      end
      cbbt_pkg::OP_SUCCESS: begin
        upd.fail_count  = 8'd0;
        upd.last_active = now_q;
        if (base.next_backoff > cfg.cooldown_initial) begin
          upd.next_backoff = (half < cfg.cooldown_initial) ? cfg.cooldown_initial : half;
        end
        upd_sweep = 1'b1;
      end
      cbbt_pkg::OP_FAILURE: begin
        upd.last_active = now_q;
        if (fail_inc >= cfg.threshold) begin
          upd.skip_count      = base.next_backoff;
          upd.next_backoff    = (doubled > {1'b0, cfg.cooldown_max}) ? cfg.cooldown_max
                                                                     : doubled[7:0];
          upd.fail_count      = 8'd0;
          upd_res.tripped     = 1'b1;
          upd_res.trip_cycles = base.next_backoff;
        end else begin
          upd.fail_count = fail_inc;
          upd_sweep      = 1'b1;
        end
      end
      default: upd = base;
    endcase
  end

  logic           last_idx;
  logic           hit;
  cbbt_pkg::idx_t free_now;
  logic           free_any;
  logic [31:0]    since_sweep;
  logic [31:0]    since_active;

  assign last_idx     = (idx_q == cbbt_pkg::idx_t'(cbbt_pkg::TABLE_ENTRIES - 1));
  assign hit          = valid_q[idx_q] && (rdata_q.host == key_q);
  assign free_any     = free_found_q || !valid_q[idx_q];
  assign free_now     = free_found_q ? free_q : idx_q;
  assign since_sweep  = now_q - last_sweep_q;
  assign since_active = now_q - rdata_q.last_active;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.skip        = out_q.skip;
  assign rsp_o.tripped     = out_q.tripped;
  assign rsp_o.trip_cycles = out_q.trip_cycles;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    free_d       = free_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    valid_d      = valid_q;
    last_sweep_d = last_sweep_q;
    op_d         = op_q;
    key_d        = key_q;
    now_d        = now_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    mem_we       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = cbbt_pkg::op_e'(req_i.operation);
          key_d   = cbbt_pkg::key_t'(req_i.host_id);
          now_d   = req_i.now_seconds;
          res_d   = '0;
          found_d = 1'b0;
          if (cbbt_pkg::op_e'(req_i.operation) == cbbt_pkg::OP_CLEAR) begin
            valid_d = '0;
            state_d = S_DONE;
          end else if (!cfg.enable || (cfg.threshold == 8'd0)) begin
            state_d = S_DONE;
          end else begin
            idx_d        = '0;
            free_found_d = 1'b0;
            state_d      = S_FIND_RD;
          end
        end
      end
      S_FIND_RD: state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        if (!valid_q[idx_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_d       = idx_q;
        end
        if (hit) begin
          found_d = 1'b1;
          slot_d  = idx_q;
          state_d = S_UPDATE;
        end else if (last_idx) begin
          if ((op_q == cbbt_pkg::OP_FAILURE) && free_any) begin
            slot_d  = free_now;
            state_d = S_UPDATE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          idx_d   = idx_q + cbbt_pkg::idx_t'(1);
          state_d = S_FIND_RD;
        end
      end
      S_UPDATE: begin
        mem_we = 1'b1;
        res_d  = upd_res;
        if (!found_q) begin
          valid_d[slot_q] = 1'b1;
        end
        state_d = upd_sweep ? S_SW_TEST : S_DONE;
      end
      S_SW_TEST: begin
        if (since_sweep >= {16'd0, cfg.reap_interval}) begin
          last_sweep_d = now_q;
          idx_d        = '0;
          state_d      = S_SW_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SW_RD: state_d = S_SW_CHK;
      S_SW_CHK: begin
        if (valid_q[idx_q] && (rdata_q.skip_count == 8'd0) &&
            (since_active > {16'd0, cfg.idle_limit})) begin
          valid_d[idx_q] = 1'b0;
        end
        if (last_idx) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + cbbt_pkg::idx_t'(1);
          state_d = S_SW_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_q] <= upd;
    end
    rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      last_sweep_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      last_sweep_q <= last_sweep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    free_q <= free_d;
    op_q   <= op_d;
    key_q  <= key_d;
    now_q  <= now_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && (req_i.operation == cbbt_pkg::OP_CLEAR)
    |=> (valid_q == '0))
    else $error("table not emptied after clear");

  a_skip_trip_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.skip && rsp_o.tripped))
    else $error("skip and tripped both set");

  a_trip_cycles_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.tripped |-> (rsp_o.trip_cycles == 8'd0))
    else $error("trip_cycles set without a trip");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cbbt_pkg::*;

  localparam int unsigned NUM_REGS    = 6;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned TAIL_CYCLES = 4 * TABLE_ENTRIES + 8;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct {
    op_e     op;
    key_t    key;
    result_t res;
  } answer_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  cbbt_req_if req_if ();
  cbbt_rsp_if rsp_if ();

  circuit_breaker_backoff_table u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // breaker table as the block should hold it
  logic        tbl_valid [TABLE_ENTRIES];
  entry_t      tbl       [TABLE_ENTRIES];
  logic [31:0] sweep_stamp;
  cfg_t        mcfg;

  answer_t     answers_due [$];
  int unsigned mismatches;
  int unsigned clock_ticks;
  int unsigned tx_gap_odds;
  int unsigned rx_stall_odds;
  logic        long_hold_req;
  bit          req_offered;
  logic [31:0] tnow;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flag_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  function automatic void reap_idle(input logic [31:0] now);
    logic [31:0] since;
    since = now - sweep_stamp;
    if (since < {16'h0, mcfg.reap_interval}) return;
    sweep_stamp = now;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl[i].skip_count == 8'd0 &&
          (now - tbl[i].last_active) > {16'h0, mcfg.idle_limit}) begin
        tbl_valid[i] = 1'b0;
      end
    end
  endfunction

  function automatic result_t predict_breaker(input op_e op, input key_t key,
                                              input logic [31:0] now);
    result_t    res;
    int         slot;
    logic [8:0] doubled;
    logic [7:0] half;
    res  = '0;
    slot = -1;
    if (op == OP_CLEAR) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      return res;
    end
    if (!mcfg.enable || mcfg.threshold == 8'd0) return res;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl[i].host == key) slot = i;
    end
    case (op)
      OP_QUERY: begin
        if (slot >= 0 && tbl[slot].skip_count != 8'd0) begin
          tbl[slot].skip_count--;
          res.skip = 1'b1;
        end
      end
      OP_SUCCESS: begin
        if (slot >= 0) begin
          tbl[slot].fail_count  = 8'd0;
          tbl[slot].last_active = now;
          if (tbl[slot].next_backoff > mcfg.cooldown_initial) begin
            half = tbl[slot].next_backoff >> 1;
            tbl[slot].next_backoff = (half < mcfg.cooldown_initial) ?
                                     mcfg.cooldown_initial : half;
          end
          reap_idle(now);
        end
      end
      default: begin
        if (slot < 0) begin
          for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) slot = i;
          end
          // fail open on a full table
          if (slot < 0) return res;
          tbl_valid[slot] = 1'b1;
          tbl[slot] = '{host: key, fail_count: 8'd0, skip_count: 8'd0,
                        next_backoff: mcfg.cooldown_initial, last_active: now};
        end
        if (tbl[slot].fail_count != 8'hFF) tbl[slot].fail_count++;
        tbl[slot].last_active = now;
        if (tbl[slot].fail_count >= mcfg.threshold) begin
          doubled                = {tbl[slot].next_backoff, 1'b0};
          tbl[slot].skip_count   = tbl[slot].next_backoff;
          tbl[slot].next_backoff = (doubled > {1'b0, mcfg.cooldown_max}) ?
                                   mcfg.cooldown_max : doubled[7:0];
          tbl[slot].fail_count   = 8'd0;
          res.tripped            = 1'b1;
          res.trip_cycles        = tbl[slot].skip_count;
        end else begin
          reap_idle(now);
        end
      end
    endcase
    return res;
  endfunction

  task automatic apb_xfer(input logic wr, input logic [ApbAddrW-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input int unsigned idx);
    logic [31:0] got;
    logic [31:0] want;
    apb_xfer(1'b0, ApbAddrW'(idx * 4), '0, got);
    case (idx)
      REG_ENABLE:           want = {31'h0, mcfg.enable};
      REG_THRESHOLD:        want = {24'h0, mcfg.threshold};
      REG_COOLDOWN_INITIAL: want = {24'h0, mcfg.cooldown_initial};
      REG_COOLDOWN_MAX:     want = {24'h0, mcfg.cooldown_max};
      REG_IDLE_LIMIT:       want = {16'h0, mcfg.idle_limit};
      default:              want = {16'h0, mcfg.reap_interval};
    endcase
    if (got !== want) begin
      flag_mismatch($sformatf("register %0d readback: expected %h, got %h", idx, want, got));
    end
  endtask

  task automatic reg_write(input int unsigned idx, input logic [31:0] value);
    logic [31:0] ignored;
    apb_xfer(1'b1, ApbAddrW'(idx * 4), value, ignored);
    case (idx)
      REG_ENABLE:           mcfg.enable           = value[0];
      REG_THRESHOLD:        mcfg.threshold        = value[7:0];
      REG_COOLDOWN_INITIAL: mcfg.cooldown_initial = value[7:0];
      REG_COOLDOWN_MAX:     mcfg.cooldown_max     = value[7:0];
      REG_IDLE_LIMIT:       mcfg.idle_limit       = value[15:0];
      REG_REAP_INTERVAL:    mcfg.reap_interval    = value[15:0];
      default: ;
    endcase
    if (idx < NUM_REGS) reg_check(idx);
  endtask

  task automatic set_config(input logic en, input logic [7:0] thr, input logic [7:0] cd_init,
                            input logic [7:0] cd_max, input logic [15:0] idle,
                            input logic [15:0] reap);
    reg_write(REG_ENABLE,           {31'($urandom), en});
    reg_write(REG_THRESHOLD,        {24'($urandom), thr});
    reg_write(REG_COOLDOWN_INITIAL, {24'($urandom), cd_init});
    reg_write(REG_COOLDOWN_MAX,     {24'($urandom), cd_max});
    reg_write(REG_IDLE_LIMIT,       {16'($urandom), idle});
    reg_write(REG_REAP_INTERVAL,    {16'($urandom), reap});
  endtask

  task automatic random_config();
    logic        en;
    logic [7:0]  thr;
    logic [7:0]  cd_init;
    logic [7:0]  cd_max;
    logic [15:0] idle;
    logic [15:0] reap;
    en = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0:       thr = 8'd0;
      1:       thr = 8'd255;
      default: thr = 8'($urandom_range(1, 5));
    endcase
    case ($urandom_range(0, 7))
      0:       cd_init = 8'd1;
      1:       cd_init = 8'd255;
      default: cd_init = 8'($urandom_range(1, 20));
    endcase
    case ($urandom_range(0, 7))
      0:       cd_max = 8'd1;
      1:       cd_max = 8'd255;
      default: cd_max = 8'($urandom_range(1, 100));
    endcase
    case ($urandom_range(0, 7))
      0:       idle = 16'd0;
      1:       idle = 16'hFFFF;
      default: idle = 16'($urandom_range(0, 30));
    endcase
    case ($urandom_range(0, 7))
      0:       reap = 16'd0;
      1:       reap = 16'hFFFF;
      default: reap = 16'($urandom_range(0, 15));
    endcase
    set_config(en, thr, cd_init, cd_max, idle, reap);
  endtask

  task automatic send_word(input op_e op, input key_t key, input logic [31:0] now);
    answer_t due;
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.host_id     <= key;
    req_if.now_seconds <= now;
    req_offered = 1'b1;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    due.op  = op;
    due.key = key;
    due.res = predict_breaker(op, key, now);
    answers_due.push_back(due);
    if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
      req_if.valid <= 1'b0;
      req_offered = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_answers();
    if (req_offered) begin
      req_if.valid <= 1'b0;
      req_offered = 1'b0;
    end
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  task automatic run_traffic(input int unsigned n, input int unsigned pool_n,
                             input int unsigned wq, input int unsigned ws,
                             input int unsigned wf, input int unsigned wc, input bit calm);
    key_t        pool [$];
    bit          taken [key_t];
    key_t        k;
    op_e         op;
    int unsigned pick;
    while (pool.size() < pool_n) begin
      k = key_t'($urandom);
      if (!taken.exists(k)) begin
        taken[k] = 1'b1;
        pool.push_back(k);
      end
    end
    repeat (n) begin
      pick = $urandom_range(0, wq + ws + wf + wc - 1);
      if (pick < wq) op = OP_QUERY;
      else if (pick < wq + ws) op = OP_SUCCESS;
      else if (pick < wq + ws + wf) op = OP_FAILURE;
      else op = OP_CLEAR;
      if ($urandom_range(0, 29) == 0) k = key_t'($urandom);
      else k = pool[$urandom_range(0, pool.size() - 1)];
      if (calm) begin
        tnow += $urandom_range(0, 1);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) tnow += $urandom_range(0, 2);
        else if (pick < 93) tnow += $urandom_range(3, 40);
        else if (pick < 99) tnow += $urandom_range(0, 70000);
        else tnow = $urandom;
      end
      send_word(op, k, tnow);
      if ($urandom_range(0, 149) == 0) drain_answers();
    end
  endtask

  task automatic test_breaker_off();
    drain_answers();
    for (int unsigned i = 0; i < NUM_REGS; i++) reg_check(i);
    send_word(OP_QUERY,   16'h0000, 32'h0000_0000);
    send_word(OP_FAILURE, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_SUCCESS, 16'hFFFF, 32'h0000_0005);
    send_word(OP_CLEAR,   16'h0000, 32'h0000_0000);
    drain_answers();
    set_config(1'b1, 8'd0, 8'd2, 8'd60, 16'd3600, 16'd60);
    reg_write(NUM_REGS, $urandom);
    reg_write(NUM_REGS + 1, $urandom);
    send_word(OP_FAILURE, 16'h1234, 32'd1);
    drain_answers();
    set_config(1'b0, 8'd1, 8'd2, 8'd60, 16'd3600, 16'd60);
    send_word(OP_FAILURE, 16'h1234, 32'd2);
  endtask

  task automatic test_trip_and_decay();
    drain_answers();
    set_config(1'b1, 8'd2, 8'd200, 8'd255, 16'hFFFF, 16'hFFFF);
    send_word(OP_FAILURE, 16'hFFFF, 32'd10);
    send_word(OP_FAILURE, 16'hFFFF, 32'd11);
    send_word(OP_QUERY,   16'hFFFF, 32'd11);
    send_word(OP_QUERY,   16'h0000, 32'd11);
    send_word(OP_SUCCESS, 16'h0000, 32'd12);
    send_word(OP_SUCCESS, 16'hFFFF, 32'd12);
    send_word(OP_FAILURE, 16'hFFFF, 32'd13);
    send_word(OP_FAILURE, 16'hFFFF, 32'd14);
    drain_answers();
    // cap below the initial cool-down
    set_config(1'b1, 8'd1, 8'd50, 8'd10, 16'hFFFF, 16'hFFFF);
    send_word(OP_FAILURE, 16'h1234, 32'd15);
    send_word(OP_SUCCESS, 16'h1234, 32'd15);
    send_word(OP_FAILURE, 16'h1234, 32'd16);
    send_word(OP_CLEAR,   16'hFFFF, 32'd16);
    send_word(OP_QUERY,   16'hFFFF, 32'd16);
  endtask

  task automatic test_reap();
    drain_answers();
    set_config(1'b1, 8'd3, 8'd1, 8'd255, 16'd0, 16'd0);
    send_word(OP_FAILURE, 16'hA5A5, 32'hFFFF_FFF0);
    send_word(OP_FAILURE, 16'h5A5A, 32'hFFFF_FFFF);
    send_word(OP_FAILURE, 16'hA5A5, 32'h0000_0002);
    send_word(OP_FAILURE, 16'hA5A5, 32'h0000_0002);
    send_word(OP_FAILURE, 16'hA5A5, 32'h0000_0002);
    send_word(OP_QUERY,   16'hA5A5, 32'h0000_0003);
  endtask

  task automatic test_random_settings();
    for (int r = 0; r < 10; r++) begin
      drain_answers();
      case (r)
        0:       set_config(1'b1, 8'd1, 8'd1, 8'd255, 16'd0, 16'd0);
        1:       set_config(1'b1, 8'd255, 8'd255, 8'd1, 16'hFFFF, 16'hFFFF);
        2:       set_config(1'b1, 8'd2, 8'd255, 8'd255, 16'd5, 16'd3);
        default: random_config();
      endcase
      tx_gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
      rx_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
      if ($urandom_range(0, 3) == 0) tnow = 32'hFFFF_FFFF - $urandom_range(0, 200);
      else tnow = $urandom;
      run_traffic(130, $urandom_range(4, 12), 35, 20, 42, 3, 1'b0);
    end
  endtask

  task automatic test_table_full();
    drain_answers();
    set_config(1'b1, 8'd200, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               16'hFFFF, 16'hFFFF);
    tx_gap_odds   = 6;
    rx_stall_odds = 6;
    tnow = $urandom;
    send_word(OP_CLEAR, key_t'($urandom), tnow);
    run_traffic(230, 72, 15, 10, 75, 0, 1'b1);
  endtask

  task automatic test_backpressure();
    drain_answers();
    set_config(1'b1, 8'd2, 8'd3, 8'd40, 16'd20, 16'd5);
    tx_gap_odds   = 0;
    rx_stall_odds = 0;
    long_hold_req <= 1'b1;
    run_traffic(60, 6, 35, 20, 42, 3, 1'b0);
    drain_answers();
  endtask

  task automatic test_steady_stream();
    drain_answers();
    random_config();
    tx_gap_odds   = 0;
    rx_stall_odds = 0;
    run_traffic(220, 10, 35, 20, 42, 3, 1'b0);
  endtask

  // response side: random stalls and one long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        hold_left = LONG_HOLD - 1;
        rsp_if.ready  <= 1'b0;
        long_hold_req <= 1'b0;
      end else if (rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
        hold_left = $urandom_range(0, 9);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    answer_t due;
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected word: skip %0b tripped %0b cycles %0d",
                                  rsp_if.skip, rsp_if.tripped, rsp_if.trip_cycles));
        end else begin
          due = answers_due.pop_front();
          if (rsp_if.skip !== due.res.skip || rsp_if.tripped !== due.res.tripped ||
              rsp_if.trip_cycles !== due.res.trip_cycles) begin
            flag_mismatch($sformatf(
              "%s host %h: expected skip %0b tripped %0b cycles %0d, got %0b %0b %0d",
              due.op.name(), due.key, due.res.skip, due.res.tripped, due.res.trip_cycles,
              rsp_if.skip, rsp_if.tripped, rsp_if.trip_cycles));
          end
        end
      end
    end
  end

  initial begin
    clock_ticks = 0;
    while (clock_ticks < CYCLE_LIMIT) begin
      @(posedge clk);
      clock_ticks++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    sweep_stamp   = '0;
    mcfg          = CfgReset;
    mismatches    = 0;
    tx_gap_odds   = 4;
    rx_stall_odds = 4;
    req_offered   = 1'b0;
    tnow          = '0;
    rst_n              <= 1'b0;
    long_hold_req      <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_QUERY;
    req_if.host_id     <= '0;
    req_if.now_seconds <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_breaker_off();
    test_trip_and_decay();
    test_reap();
    test_random_settings();
    test_table_full();
    test_backpressure();
    test_steady_stream();

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (answers_due.size() != 0) begin
      flag_mismatch($sformatf("%0d words never arrived", answers_due.size()));
    end
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
